@@ hdl/cmkx_pkg.sv @@
package cmkx_pkg;

  // Command codes carried on the input channel.
  typedef enum logic {
    CMD_STRING = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] KEY_SEED_RST     = 8'd0;
  localparam logic [9:0] START_OFFSET_RST = 10'd4;

  // Character classes and position limit.
  localparam logic [7:0]  CHAR_LIMIT   = 8'd127;
  localparam logic [7:0]  CHAR_PERCENT = 8'd37;
  localparam logic [7:0]  CHAR_PERIOD  = 8'd46;
  localparam logic [10:0] POSITION_MAX = 11'd2047;

  // One input beat.
  typedef struct packed {
    cmd_t       command;
    logic [7:0] value;
    logic       first;
    logic       last;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] coded_byte;
    logic       end_of_message;
  } result_t;

endpackage

@@ hdl/cmkx_if.sv @@
// Input channel: key string bytes and message bytes.
interface cmkx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] value;
  logic       first;
  logic       last;

  modport source (output valid, output command, output value, output first,
                  output last, input ready);
  modport sink   (input valid, input command, input value, input first,
                  input last, output ready);
endinterface

// Result channel: coded message bytes.
interface cmkx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic       end_of_message;

  modport source (output valid, output coded_byte, output end_of_message, input ready);
  modport sink   (input valid, input coded_byte, input end_of_message, output ready);
endinterface

@@ hdl/command_keyed_xor_stream_coder.sv @@
// Running-XOR message coder. Load the key string first as string beats
// (command 0, first on the opening character); then send message beats
// (command 1, first on the opening byte). Each message beat gives one coded
// beat, string beats give none. The block takes one beat in every cycle
// while the skid entry is empty: the key update is a single XOR fed by a
// store read prefetched one entry ahead, and the coded byte is registered
// in a two-entry output queue (output register and skid entry) that lets
// input continue for one beat while the output is stalled. key_seed takes
// effect at the next first message beat; write configuration only while
// the block is idle. The string store needs no clearing after reset.
module command_keyed_xor_stream_coder
  import cmkx_pkg::*;
#(
  parameter int STRING_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cmkx_in_if.sink               in_ch,
  cmkx_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t   item;
  logic    accept;
  logic    res_valid;
  result_t res;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  // Input beat.
  always_comb begin
    item.command = cmd_t'(in_ch.command);
    item.value   = in_ch.value;
    item.first   = in_ch.first;
    item.last    = in_ch.last;
    in_ch.ready  = !skid_v_r;
    accept       = in_ch.valid && in_ch.ready;
  end

  cmkx_keystream #(
    .STRING_DEPTH (STRING_DEPTH)
  ) u_keystream (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .item_accept (accept),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with a skid entry behind it.
  always_comb begin
    pop        = out_v_r && out_ch.ready;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_r || pop) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  always_comb begin
    out_ch.valid          = out_v_r;
    out_ch.coded_byte     = out_d_r.coded_byte;
    out_ch.end_of_message = out_d_r.end_of_message;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && !skid_v_r && res_valid |=> skid_v_r)
    else $error("coded beat lost while the output was stalled");

endmodule

@@ hdl/cmkx_keystream.sv @@
module cmkx_keystream
  import cmkx_pkg::*;
#(
  parameter int STRING_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_accept,
  input  item_t                 item,
  output logic                  res_valid,
  output result_t               res
);

  localparam int AW = $clog2(STRING_DEPTH);
  localparam int PW = AW + 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(STRING_DEPTH - 1);

  // Next read index, wrapping at the end of the store.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + AW'(1);
  endfunction

  logic [7:0]    store_mem [STRING_DEPTH];

  logic [7:0]    key_seed_r;
  logic [9:0]    start_offset_r;
  logic [PW-1:0] load_ptr_r, load_ptr_nxt;
  logic [AW-1:0] read_idx_r, read_idx_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [10:0]   pos_r, pos_nxt;
  logic          par_r, par_nxt;
  // Raw store contents at the read index, the entry after it, and entries 0 and 1.
  logic [7:0]    cur_char_r, cur_char_nxt;
  logic [7:0]    next_char_r;
  logic [7:0]    ch0_r;
  logic [7:0]    ch1_r;

  logic          str_wr, dat;
  logic [PW-1:0] wr_ptr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] idx0;
  logic [7:0]    raw0, rawn, key0;
  logic [10:0]   pos0;
  logic          par0, active, nul;
  logic [7:0]    cval, c0val, csel, cmap, shifted, key1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r     <= KEY_SEED_RST;
      start_offset_r <= START_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_SEED:     key_seed_r     <= cfg_wdata[7:0];
        REG_START_OFFSET: start_offset_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // String loading.
  always_comb begin
    str_wr       = item_accept && (item.command == CMD_STRING);
    dat          = item_accept && (item.command == CMD_DATA);
    wr_ptr       = item.first ? '0 : load_ptr_r;
    wr_en        = str_wr && (wr_ptr < PW'(STRING_DEPTH));
    wr_addr      = wr_ptr[AW-1:0];
    load_ptr_nxt = wr_en ? wr_ptr + PW'(1) : (str_wr ? wr_ptr : load_ptr_r);
  end

  // Key update for one message beat; a first beat starts from the seed.
  always_comb begin
    idx0    = item.first ? '0 : read_idx_r;
    raw0    = item.first ? ch0_r : cur_char_r;
    rawn    = item.first ? ch1_r : next_char_r;
    key0    = item.first ? key_seed_r : key_r;
    pos0    = item.first ? '0 : pos_r;
    par0    = item.first ? 1'b0 : par_r;
    active  = pos0 >= {1'b0, start_offset_r};
    cval    = ({1'b0, idx0} < load_ptr_r) ? raw0 : 8'd0;
    nul     = (cval == 8'd0);
    c0val   = (load_ptr_r != '0) ? ch0_r : 8'd0;
    csel    = nul ? c0val : cval;
    cmap    = (csel > CHAR_LIMIT || csel == CHAR_PERCENT) ? CHAR_PERIOD : csel;
    shifted = par0 ? {cmap[6:0], 1'b0} : cmap;
    key1    = key0 ^ shifted;
  end

  // Next state of the running key, position and read index.
  always_comb begin
    read_idx_nxt = read_idx_r;
    cur_char_nxt = cur_char_r;
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    par_nxt      = par_r;
    if (dat) begin
      key_nxt = active ? key1 : key0;
      pos_nxt = (pos0 < POSITION_MAX) ? pos0 + 11'd1 : pos0;
      par_nxt = ~par0;
      if (!active) begin
        read_idx_nxt = idx0;
        cur_char_nxt = raw0;
      end else if (nul) begin
        read_idx_nxt = AW'(1);
        cur_char_nxt = ch1_r;
      end else begin
        read_idx_nxt = wrap_inc(idx0);
        cur_char_nxt = rawn;
      end
    end
    // A string write to the entry under the read index refreshes its copy.
    if (wr_en && wr_addr == read_idx_r) begin
      cur_char_nxt = item.value;
    end
    rd_addr = wrap_inc(read_idx_nxt);
  end

  // Result of the beat.
  always_comb begin
    res_valid          = dat;
    res.coded_byte     = active ? (item.value ^ key1) : item.value;
    res.end_of_message = item.last;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r <= '0;
      read_idx_r <= '0;
      key_r      <= '0;
      pos_r      <= '0;
      par_r      <= 1'b0;
    end else begin
      load_ptr_r <= load_ptr_nxt;
      read_idx_r <= read_idx_nxt;
      key_r      <= key_nxt;
      pos_r      <= pos_nxt;
      par_r      <= par_nxt;
    end
  end

  // Character copies; their validity comes from the load pointer.
  always_ff @(posedge clk) begin
    cur_char_r <= cur_char_nxt;
    if (wr_en && wr_addr == '0) begin
      ch0_r <= item.value;
    end
    if (wr_en && wr_addr == AW'(1)) begin
      ch1_r <= item.value;
    end
  end

  // String store: one write port, one registered read port with write bypass.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= item.value;
    end
    next_char_r <= (wr_en && wr_addr == rd_addr) ? item.value : store_mem[rd_addr];
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_idx_r <= IDX_LAST)
    else $error("read index beyond the store");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_ptr_r <= PW'(STRING_DEPTH))
    else $error("load pointer beyond the store");

  a_pass_before_offset: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !active |-> res.coded_byte == item.value)
    else $error("byte before the start offset was altered");

  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    dat && item.first |=> pos_r == 11'd1 && par_r)
    else $error("first message beat did not restart position and parity");

endmodule
